/* hdl/assert_macros.svh */
// assertion macros used by the top-level rtl file
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// trigger at one edge implies result at the next
`define ASSERT_NEXT(lbl, trig, res) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (res)) \
    else $error("assertion failed");

`endif

/* hdl/esc_pkg.sv */
// types, register indexes and arithmetic helpers for the sensor compensation block
// no dependencies
package esc_pkg;

  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP_CALIB   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRES_CALIB_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRES_CALIB_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_CALIB_A  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_CALIB_B  = 3'd4;

  localparam int DIV_STEPS = 32;

  localparam logic [31:0] HUM_MAX = 32'd419430400;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_pres;
    logic [15:0] raw_hum;
  } in_t;

  typedef struct packed {
    logic signed [31:0] temperature;
    logic [31:0]        pressure;
    logic [16:0]        humidity;
  } out_t;

  // wrapping 32-bit product
  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned s);
    logic signed [31:0] t;
    t = $signed(x) >>> s;
    return t;
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx12(input logic [11:0] v);
    return {{20{v[11]}}, v};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

endpackage

/* hdl/env_sensor_compensation.sv */
// top level of the sensor compensation pipeline
// depends on esc_pkg and assert_macros.svh
`include "assert_macros.svh"
//
//  channel | ports                          | moves
//  --------+--------------------------------+-------------------------------
//  input   | in_valid in_ready in_data      | raw temp / pres / hum item
//  result  | out_valid out_ready out_data   | compensated item
//  config  | cfg_we cfg_addr cfg_wdata      | calibration word write
//
//  one item per cycle sustained while the output is not stalled; each item runs
//  through 9 front stages, the 32-step restoring divider of the pressure path,
//  one quotient bit per stage, and 3 back stages
//  synchronous active-low reset clears the valid bits and calibration words
//  the whole pipe advances when the output register is empty or being taken;
//  a stall freezes every stage, so nothing is lost or repeated
module env_sensor_compensation (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  esc_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output esc_pkg::out_t                     out_data,
  input  logic                              cfg_we,
  input  logic [esc_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [esc_pkg::CFG_W-1:0]         cfg_wdata
);
  import esc_pkg::*;

  localparam int FRONT = 9;
  localparam int BACK  = 3;
  localparam int NST   = FRONT + DIV_STEPS + BACK;

  // calibration registers
  logic [47:0] temp_calib_r;
  logic [63:0] pres_calib_a_r, pres_calib_b_r;
  logic [47:0] hum_calib_a_r;
  logic [31:0] hum_calib_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_calib_r   <= '0;
      pres_calib_a_r <= '0;
      pres_calib_b_r <= '0;
      hum_calib_a_r  <= '0;
      hum_calib_b_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TEMP_CALIB:   temp_calib_r   <= cfg_wdata[47:0];
        REG_PRES_CALIB_A: pres_calib_a_r <= cfg_wdata;
        REG_PRES_CALIB_B: pres_calib_b_r <= cfg_wdata;
        REG_HUM_CALIB_A:  hum_calib_a_r  <= cfg_wdata[47:0];
        REG_HUM_CALIB_B:  hum_calib_b_r  <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // calibration fields, widened to 32 bits
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;
  assign t1 = {16'b0, temp_calib_r[15:0]};
  assign t2 = sx16(temp_calib_r[31:16]);
  assign t3 = sx16(temp_calib_r[47:32]);
  assign p1 = {16'b0, pres_calib_a_r[15:0]};
  assign p2 = sx16(pres_calib_a_r[31:16]);
  assign p3 = sx16(pres_calib_a_r[47:32]);
  assign p4 = sx16(pres_calib_a_r[63:48]);
  assign p5 = sx16(pres_calib_b_r[15:0]);
  assign p6 = sx16(pres_calib_b_r[31:16]);
  assign p7 = sx16(pres_calib_b_r[47:32]);
  assign p8 = sx16(pres_calib_b_r[63:48]);
  assign p9 = sx16(hum_calib_a_r[15:0]);
  assign h1 = {24'b0, hum_calib_a_r[23:16]};
  assign h2 = sx16(hum_calib_a_r[39:24]);
  assign h3 = {24'b0, hum_calib_a_r[47:40]};
  assign h4 = sx12(hum_calib_b_r[11:0]);
  assign h5 = sx12(hum_calib_b_r[23:12]);
  assign h6 = sx8(hum_calib_b_r[31:24]);

  // pipeline control: one enable for all stages
  logic           en;
  logic [NST-1:0] vld_r;
  assign en        = !vld_r[NST-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // front stages: temperature, pressure setup, humidity
  logic [31:0] at32, ap32, ah32;
  assign at32 = {12'b0, in_data.raw_temp};
  assign ap32 = {12'b0, in_data.raw_pres};
  assign ah32 = {16'b0, in_data.raw_hum};

  logic [31:0] s1_v1t_r, s1_dd_r, s1_ap_r, s1_ah_r;
  logic [31:0] s2_tf_r, s2_ap_r, s2_ah_r;
  logic [31:0] s3_temp_r, s3_sq_r, s3_pv1p5_r, s3_p2v1_r;
  logic [31:0] s3_xh6_r, s3_xh3_r, s3_h5x_r, s3_ap_r, s3_ah_r;
  logic [31:0] s4_v2a_r, s4_pv1p5_r, s4_p3s_r, s4_p2v1_r, s4_a_r, s4_bb_r;
  logic [31:0] s4_temp_r, s4_ap_r;
  logic [31:0] s5_v2_r, s5_t_r, s5_hb_r, s5_a_r, s5_temp_r, s5_ap_r;
  logic [31:0] s6_dv_r, s6_nm_r, s6_b_r, s6_a_r, s6_temp_r;
  logic [31:0] s7_hx_r, s7_num_r, s7_den_r, s7_temp_r;
  logic        s7_zero_r, s7_dbl_r;
  logic [31:0] s8_hx_r, s8_ss_r, s8_num_r, s8_den_r, s8_temp_r;
  logic        s8_zero_r, s8_dbl_r;
  logic [16:0] s9_hum_r;
  logic [31:0] s9_num_r, s9_den_r, s9_temp_r;
  logic        s9_zero_r, s9_dbl_r;

  logic [31:0] c1_a1, c1_d, c3_pv1, c3_q, c3_x, c5_v2, c5_v1, c9_h, c9_hc;
  always_comb begin
    c1_a1  = (at32 >> 3) - (t1 << 1);
    c1_d   = (at32 >> 4) - t1;
    c3_pv1 = asr(s2_tf_r, 1) - 32'd64000;
    c3_q   = asr(c3_pv1, 2);
    c3_x   = s2_tf_r - 32'd76800;
    c5_v2  = s4_v2a_r + (s4_pv1p5_r << 1);
    c5_v1  = asr(asr(s4_p3s_r, 3) + asr(s4_p2v1_r, 1), 18);
    c9_h   = s8_hx_r - asr(mul32(asr(s8_ss_r, 7), h1), 4);
    // clamp the pre-scaled humidity to 0..100 %rh
    if (c9_h[31]) begin
      c9_hc = '0;
    end else if (c9_h > HUM_MAX) begin
      c9_hc = HUM_MAX;
    end else begin
      c9_hc = c9_h;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: first temperature products
      s1_v1t_r <= asr(mul32(c1_a1, t2), 11);
      s1_dd_r  <= mul32(c1_d, c1_d);
      s1_ap_r  <= ap32;
      s1_ah_r  <= ah32;
      // stage 2: fine temperature
      s2_tf_r  <= s1_v1t_r + asr(mul32(asr(s1_dd_r, 12), t3), 14);
      s2_ap_r  <= s1_ap_r;
      s2_ah_r  <= s1_ah_r;
      // stage 3: temperature out, products on fine temperature
      s3_temp_r  <= asr((s2_tf_r << 2) + s2_tf_r + 32'd128, 8);
      s3_sq_r    <= mul32(c3_q, c3_q);
      s3_pv1p5_r <= mul32(c3_pv1, p5);
      s3_p2v1_r  <= mul32(p2, c3_pv1);
      s3_xh6_r   <= mul32(c3_x, h6);
      s3_xh3_r   <= mul32(c3_x, h3);
      s3_h5x_r   <= mul32(h5, c3_x);
      s3_ap_r    <= s2_ap_r;
      s3_ah_r    <= s2_ah_r;
      // stage 4
      s4_v2a_r   <= mul32(asr(s3_sq_r, 11), p6);
      s4_pv1p5_r <= s3_pv1p5_r;
      s4_p3s_r   <= mul32(p3, asr(s3_sq_r, 13));
      s4_p2v1_r  <= s3_p2v1_r;
      s4_a_r     <= asr((s3_ah_r << 14) - (h4 << 20) - s3_h5x_r + 32'd16384, 15);
      s4_bb_r    <= mul32(asr(s3_xh6_r, 10), asr(s3_xh3_r, 11) + 32'd32768);
      s4_temp_r  <= s3_temp_r;
      s4_ap_r    <= s3_ap_r;
      // stage 5: divisor product and offset term
      s5_v2_r   <= asr(c5_v2, 2) + (p4 << 16);
      s5_t_r    <= mul32(32'd32768 + c5_v1, p1);
      s5_hb_r   <= mul32(asr(s4_bb_r, 10) + 32'd2097152, h2);
      s5_a_r    <= s4_a_r;
      s5_temp_r <= s4_temp_r;
      s5_ap_r   <= s4_ap_r;
      // stage 6: divisor and dividend
      s6_dv_r   <= asr(s5_t_r, 15);
      s6_nm_r   <= mul32((32'd1048576 - s5_ap_r) - asr(s5_v2_r, 12), 32'd3125);
      s6_b_r    <= asr(s5_hb_r + 32'd8192, 14);
      s6_a_r    <= s5_a_r;
      s6_temp_r <= s5_temp_r;
      // stage 7: humidity product, divider setup
      s7_hx_r   <= mul32(s6_a_r, s6_b_r);
      s7_zero_r <= (s6_dv_r == '0);
      s7_dbl_r  <= s6_nm_r[31];
      s7_num_r  <= s6_nm_r[31] ? s6_nm_r : (s6_nm_r << 1);
      s7_den_r  <= s6_dv_r;
      s7_temp_r <= s6_temp_r;
      // stage 8
      s8_hx_r   <= s7_hx_r;
      s8_ss_r   <= mul32(asr(s7_hx_r, 15), asr(s7_hx_r, 15));
      s8_num_r  <= s7_num_r;
      s8_den_r  <= s7_den_r;
      s8_zero_r <= s7_zero_r;
      s8_dbl_r  <= s7_dbl_r;
      s8_temp_r <= s7_temp_r;
      // stage 9: humidity final
      s9_hum_r  <= c9_hc[28:12];
      s9_num_r  <= s8_num_r;
      s9_den_r  <= s8_den_r;
      s9_zero_r <= s8_zero_r;
      s9_dbl_r  <= s8_dbl_r;
      s9_temp_r <= s8_temp_r;
    end
  end

  // restoring divider, one quotient bit per stage
  logic [31:0] dv_rem_r  [DIV_STEPS];
  logic [31:0] dv_num_r  [DIV_STEPS];
  logic [31:0] dv_quo_r  [DIV_STEPS];
  logic [31:0] dv_den_r  [DIV_STEPS];
  logic [31:0] dv_temp_r [DIV_STEPS];
  logic [16:0] dv_hum_r  [DIV_STEPS];
  logic        dv_zero_r [DIV_STEPS];
  logic        dv_dbl_r  [DIV_STEPS];

  logic [31:0] dv_rem_nxt [DIV_STEPS];
  logic [31:0] dv_quo_nxt [DIV_STEPS];
  logic [32:0] dv_trial   [DIV_STEPS];
  logic [31:0] dv_rem_in  [DIV_STEPS];
  logic [31:0] dv_num_in  [DIV_STEPS];
  logic [31:0] dv_quo_in  [DIV_STEPS];
  logic [31:0] dv_den_in  [DIV_STEPS];

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (k == 0) begin
        dv_rem_in[k] = '0;
        dv_num_in[k] = s9_num_r;
        dv_quo_in[k] = '0;
        dv_den_in[k] = s9_den_r;
      end else begin
        dv_rem_in[k] = dv_rem_r[k-1];
        dv_num_in[k] = dv_num_r[k-1];
        dv_quo_in[k] = dv_quo_r[k-1];
        dv_den_in[k] = dv_den_r[k-1];
      end
      dv_trial[k] = {dv_rem_in[k], dv_num_in[k][31]};
      if (dv_trial[k] >= {1'b0, dv_den_in[k]}) begin
        dv_rem_nxt[k] = 32'(dv_trial[k] - {1'b0, dv_den_in[k]});
        dv_quo_nxt[k] = {dv_quo_in[k][30:0], 1'b1};
      end else begin
        dv_rem_nxt[k] = dv_trial[k][31:0];
        dv_quo_nxt[k] = {dv_quo_in[k][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        dv_rem_r[k] <= dv_rem_nxt[k];
        dv_quo_r[k] <= dv_quo_nxt[k];
        dv_num_r[k] <= dv_num_in[k] << 1;
        dv_den_r[k] <= dv_den_in[k];
        if (k == 0) begin
          dv_temp_r[k] <= s9_temp_r;
          dv_hum_r[k]  <= s9_hum_r;
          dv_zero_r[k] <= s9_zero_r;
          dv_dbl_r[k]  <= s9_dbl_r;
        end else begin
          dv_temp_r[k] <= dv_temp_r[k-1];
          dv_hum_r[k]  <= dv_hum_r[k-1];
          dv_zero_r[k] <= dv_zero_r[k-1];
          dv_dbl_r[k]  <= dv_dbl_r[k-1];
        end
      end
    end
  end

  // back stages: pressure correction
  logic [31:0] q_pres;
  assign q_pres = dv_dbl_r[DIV_STEPS-1] ? (dv_quo_r[DIV_STEPS-1] << 1)
                                        : dv_quo_r[DIV_STEPS-1];

  logic [31:0] b1_pres_r, b1_sqp_r, b1_pp8_r, b1_temp_r;
  logic [16:0] b1_hum_r;
  logic        b1_zero_r;
  logic [31:0] b2_pres_r, b2_v1_r, b2_v2_r, b2_temp_r;
  logic [16:0] b2_hum_r;
  logic        b2_zero_r;
  out_t        out_r;

  always_ff @(posedge clk) begin
    if (en) begin
      b1_pres_r <= q_pres;
      b1_sqp_r  <= mul32(q_pres >> 3, q_pres >> 3);
      b1_pp8_r  <= mul32(q_pres >> 2, p8);
      b1_temp_r <= dv_temp_r[DIV_STEPS-1];
      b1_hum_r  <= dv_hum_r[DIV_STEPS-1];
      b1_zero_r <= dv_zero_r[DIV_STEPS-1];

      b2_pres_r <= b1_pres_r;
      b2_v1_r   <= asr(mul32(p9, b1_sqp_r >> 13), 12);
      b2_v2_r   <= asr(b1_pp8_r, 13);
      b2_temp_r <= b1_temp_r;
      b2_hum_r  <= b1_hum_r;
      b2_zero_r <= b1_zero_r;

      // output register; zero divisor forces zero pressure
      out_r.temperature <= $signed(b2_temp_r);
      out_r.pressure    <= b2_zero_r ? '0
                           : b2_pres_r + asr(b2_v1_r + b2_v2_r + p7, 4);
      out_r.humidity    <= b2_hum_r;
    end
  end

  assign out_data = out_r;

  // checks
  `ASSERT_ALWAYS(a_hum_range, !out_valid || (out_data.humidity <= 17'd102400))
  `ASSERT_NEXT(a_stall_freeze, !en, $stable(vld_r))
  `ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld_r[0])
  `ASSERT_NEXT(a_zero_div, vld_r[NST-2] && b2_zero_r && en, out_data.pressure == 32'd0)

endmodule
